// ----- hdl/htt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htt_pkg: handle translation table definitions
// Table size, field widths, action and status codes, the decoded item type.
// ----------------------------------------------------------------------------
package htt_pkg;

  localparam int ENTRIES  = 16;
  localparam int ID_W     = 5;
  localparam int HANDLE_W = 16;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int SLOT_W   = $clog2(ENTRIES);

  localparam logic [1:0] ACT_OPEN   = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_CLOSE  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    OP_OPEN,
    OP_LOOKUP,
    OP_CLOSE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/htt_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htt_req_if: request channel
// Valid/ready channel carrying one table action per item.
// ----------------------------------------------------------------------------
interface htt_req_if import htt_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [ID_W-1:0]     client_id;
  logic [HANDLE_W-1:0] server_handle;

  modport source (output valid, action, client_id, server_handle, input ready);
  modport sink   (input valid, action, client_id, server_handle, output ready);

endinterface

`default_nettype wire

// ----- hdl/htt_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htt_rsp_if: result channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface htt_rsp_if import htt_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [ID_W-1:0]     allocated_id;
  logic [HANDLE_W-1:0] found_handle;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, status, allocated_id, found_handle, entry_count,
                  input ready);
  modport sink   (input valid, status, allocated_id, found_handle, entry_count,
                  output ready);

endinterface

`default_nettype wire

// ----- hdl/htt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htt_front: request decode and command queue
// Accepts request items, decodes the action and holds up to two commands
// for the table engine.
// ----------------------------------------------------------------------------
module htt_front import htt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  htt_req_if.sink   req,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic cmd_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  cmd_t       dec;

  always_comb begin
    dec.id     = req.client_id;
    dec.handle = req.server_handle;
    unique case (req.action)
      ACT_OPEN:   dec.op = OP_OPEN;
      ACT_LOOKUP: dec.op = OP_LOOKUP;
      ACT_CLOSE:  dec.op = OP_CLOSE;
      default:    dec.op = OP_NONE;
    endcase
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/htt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htt_back: table engine
// Holds the packed slot table and in-use id map and registers the result item;
// per-slot compare and shift do one command per cycle while results are taken.
// ----------------------------------------------------------------------------
module htt_back import htt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  htt_rsp_if.source rsp
);

  logic [ID_W-1:0]     slot_id     [ENTRIES];
  logic [HANDLE_W-1:0] slot_handle [ENTRIES];
  logic [ENTRIES-1:0]  slot_valid;
  logic [ENTRIES-1:0]  id_used;   // bit k set: client id k+1 is in the table
  logic [CNT_W-1:0]    count;

  logic                rsp_valid;
  logic [1:0]          rsp_status;
  logic [ID_W-1:0]     rsp_alloc;
  logic [HANDLE_W-1:0] rsp_found;
  logic [CNT_W-1:0]    rsp_count;

  logic [ENTRIES-1:0]  hit;
  logic [ENTRIES-1:0]  shift_en;   // slots at or above the removed one
  logic                hit_any;
  logic [HANDLE_W-1:0] hit_handle;
  logic [SLOT_W-1:0]   free_idx;
  logic [ID_W-1:0]     new_id;
  logic                full;
  logic [SLOT_W-1:0]   tail;
  logic [SLOT_W-1:0]   del_idx;
  logic                do_open;
  logic                do_close;
  logic [ENTRIES-1:0]  prefix_mask;

  logic [1:0]          status_next;
  logic [ID_W-1:0]     alloc_next;
  logic [HANDLE_W-1:0] found_next;
  logic [CNT_W-1:0]    count_next;

  assign cmd_pop = cmd_valid && (!rsp_valid || rsp.ready);

  always_comb begin
    hit_handle = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = slot_valid[i] && (slot_id[i] == cmd.id);
      if (hit[i]) begin
        hit_handle = hit_handle | slot_handle[i];
      end
    end
    hit_any = |hit;
    for (int i = 0; i < ENTRIES; i++) begin
      shift_en[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        shift_en[i] = shift_en[i] | hit[j];
      end
    end
  end

  // Lowest clear bit of the in-use map gives the smallest free id.
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!id_used[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign new_id  = ID_W'(free_idx) + ID_W'(1);
  assign full    = (count == CNT_W'(ENTRIES));
  assign tail    = count[SLOT_W-1:0];
  assign del_idx = SLOT_W'(cmd.id - ID_W'(1));
  assign do_open  = cmd_pop && (cmd.op == OP_OPEN) && !full;
  assign do_close = cmd_pop && (cmd.op == OP_CLOSE) && hit_any;

  always_comb begin
    status_next = ST_OK;
    alloc_next  = '0;
    found_next  = '0;
    count_next  = count;
    unique case (cmd.op)
      OP_OPEN: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          alloc_next = new_id;
          count_next = count + CNT_W'(1);
        end
      end
      OP_LOOKUP: begin
        if (hit_any) begin
          found_next = hit_handle;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_CLOSE: begin
        if (hit_any) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // On close the last slot is always within the shifted range.
  always_ff @(posedge clk) begin
    if (do_open) begin
      slot_id[tail]     <= new_id;
      slot_handle[tail] <= cmd.handle;
    end else if (do_close) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (shift_en[i]) begin
          slot_id[i]     <= slot_id[i+1];
          slot_handle[i] <= slot_handle[i+1];
        end
      end
      slot_id[ENTRIES-1]     <= '0;
      slot_handle[ENTRIES-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      id_used    <= '0;
      count      <= '0;
    end else if (cmd_pop) begin
      count <= count_next;
      if (do_open) begin
        slot_valid[tail]  <= 1'b1;
        id_used[free_idx] <= 1'b1;
      end else if (do_close) begin
        id_used[del_idx] <= 1'b0;
        for (int i = 0; i < ENTRIES - 1; i++) begin
          if (shift_en[i]) begin
            slot_valid[i] <= slot_valid[i+1];
          end
        end
        slot_valid[ENTRIES-1] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd_pop) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rsp_status <= status_next;
      rsp_alloc  <= alloc_next;
      rsp_found  <= found_next;
      rsp_count  <= count_next;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.allocated_id = rsp_alloc;
  assign rsp.found_handle = rsp_found;
  assign rsp.entry_count  = rsp_count;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      prefix_mask[i] = (CNT_W'(i) < count);
    end
  end

  a_packed: assert property (@(posedge clk) disable iff (rst)
    slot_valid == prefix_mask)
    else $error("occupied slots do not form a prefix");

  a_ids_match_count: assert property (@(posedge clk) disable iff (rst)
    $countones(id_used) == int'(count))
    else $error("in-use id map disagrees with entry count");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL) |-> rsp_count == CNT_W'(ENTRIES))
    else $error("full reported on a table that is not full");

  a_close_shrinks: assert property (@(posedge clk) disable iff (rst)
    do_close |=> count == $past(count) - CNT_W'(1))
    else $error("close did not remove exactly one entry");

endmodule

`default_nettype wire

// ----- hdl/handle_translation_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// handle_translation_table: client id to server handle map
// Open allocates the lowest free client id, lookup returns the handle,
// close removes an entry and keeps the table packed.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                              
//  req      in   action, client_id, server_handle                    
//  rsp      out  status, allocated_id, found_handle, entry_count     
//
//  Request items go into a two-deep command queue; the table engine takes
//  one command per cycle while results are taken, so one item per cycle is
//  sustained. A result item passes through the queue register, then the
//  result register, before it is shown.
//  Reset empties the table at once; no clearing pass is needed.
//  A stalled result holds the engine; the queue keeps taking items until full.
// ----------------------------------------------------------------------------
module handle_translation_table import htt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  htt_req_if.sink   req,
  htt_rsp_if.source rsp
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  htt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  htt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
